// ===== rtl/core/sntp_pkg.sv =====
// shared types and constants of the sntp exchange controller
package sntp_pkg;

  localparam int unsigned TimeoutW = 16;
  localparam int unsigned RetryW   = 4;
  localparam int unsigned ByteCntW = 6;
  localparam int unsigned MillisW  = 41;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteCntW-1:0] PktLen      = 6'd48;
  localparam logic [ByteCntW-1:0] SecFirst    = 6'd40;
  localparam logic [ByteCntW-1:0] FracFirst   = 6'd44;
  localparam logic [31:0]         EpochOffset = 32'd2208988800;
  localparam logic [41:0]         MsPerSec    = 42'd1000;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd3000;
  localparam logic [RetryW-1:0]   RetryReset   = 4'd3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_BYTE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_BAD     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_START,
    EV_TIMEOUT,
    EV_REPLY
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT_TICKS = 1'd0,
    CFG_MAX_RETRIES   = 1'd1
  } cfg_idx_e;

endpackage

// ===== rtl/core/sntp_if.sv =====
// channel interfaces of the sntp exchange controller

interface sntp_in_if import sntp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, kind, rx_byte, rx_last, input ready);
  modport sink   (input valid, kind, rx_byte, rx_last, output ready);
endinterface

interface sntp_out_if import sntp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               send_query;
  logic               done_res;
  logic [1:0]         status;
  logic [MillisW-1:0] unix_ms;

  modport source (output valid, send_query, done_res, status, unix_ms, input ready);
  modport sink   (input valid, send_query, done_res, status, unix_ms, output ready);
endinterface

interface sntp_cfg_if import sntp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_idx;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ===== rtl/core/sntp_exchange_controller.sv =====
// sntp client exchange controller: query timing, retries and reply decoding
//
// in_i carries one event per transaction: start, timer tick or reply byte
// (rx_byte, with rx_last on the final byte of a packet). out_o gives one
// result transaction for every input transaction, in order: send_query asks
// for the 48-byte client query, done_res marks the end of an exchange,
// status is the latest exchange status and unix_ms the latest time.
// cfg_i writes timeout_ticks (index 0) and max_retries (index 1); it is
// always ready; the user must use it only while the block is idle, which
// the block itself does not enforce. throughput: one transaction per cycle
// while out_o does not stall; the exchange state updates in the accepting
// cycle, and the timestamp conversion (two constant multiplies and an add)
// fills the stage in front of the output register.
// reset: idle, status busy or none yet, unix_ms zero, registers at 3000
// ticks and 3 retries; no clearing pass.
// when out_o stalls, the token stage still takes one more transaction and
// in_i.ready then drops until the output drains.
module sntp_exchange_controller import sntp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sntp_in_if.sink    in_i,
  sntp_out_if.source out_o,
  sntp_cfg_if.sink   cfg_i
);

  logic [TimeoutW-1:0] timeout_q;
  logic [RetryW-1:0]   max_retries_q;

  phase_e              phase_q, phase_d;
  logic [RetryW-1:0]   retry_q, retry_d;
  logic [TimeoutW-1:0] tick_q, tick_d;
  logic [ByteCntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [2:0]          mode_q, mode_d;
  logic [31:0]         sec_q, sec_d;
  logic [31:0]         frac_q, frac_d;

  logic                tok_valid_q;
  logic                tok_send_q, tok_send_d;
  event_e              tok_ev_q, tok_ev_d;
  logic [2:0]          tok_mode_q;
  logic [31:0]         tok_sec_q;
  logic [31:0]         tok_frac_q;

  logic                out_valid_q;
  logic                send_q, done_q, done_d;
  status_e             status_q, status_d;
  logic [MillisW-1:0]  ms_q, ms_d;

  logic                in_acc, tok_adv;
  logic [TimeoutW:0]   tick_next;
  logic [ByteCntW-1:0] idx_next;
  logic [31:0]         secs_rel;
  logic [41:0]         prod_sec, prod_frac, ms_full;
  logic                reply_ok;

  // handshakes
  assign tok_adv     = tok_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !tok_valid_q || tok_adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TimeoutReset;
      max_retries_q <= RetryReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_idx == CFG_TIMEOUT_TICKS) begin
        timeout_q <= cfg_i.wdata[TimeoutW-1:0];
      end else begin
        max_retries_q <= cfg_i.wdata[RetryW-1:0];
      end
    end
  end

  // exchange state update
  always_comb begin
    phase_d    = phase_q;
    retry_d    = retry_q;
    tick_d     = tick_q;
    byte_cnt_d = byte_cnt_q;
    mode_d     = mode_q;
    sec_d      = sec_q;
    frac_d     = frac_q;
    tok_send_d = 1'b0;
    tok_ev_d   = EV_NONE;
    tick_next  = {1'b0, tick_q} + {{TimeoutW{1'b0}}, 1'b1};
    idx_next   = byte_cnt_q;

    unique case (in_i.kind)
      KIND_START: begin
        phase_d    = PH_WAIT;
        retry_d    = '0;
        tick_d     = '0;
        byte_cnt_d = '0;
        tok_send_d = 1'b1;
        tok_ev_d   = EV_START;
      end
      KIND_TICK: begin
        if (phase_q == PH_WAIT) begin
          if (tick_next >= {1'b0, timeout_q}) begin
            tick_d = '0;
            if (retry_q >= max_retries_q) begin
              phase_d    = PH_IDLE;
              byte_cnt_d = '0;
              tok_ev_d   = EV_TIMEOUT;
            end else begin
              retry_d    = retry_q + 1'b1;
              tok_send_d = 1'b1;
            end
          end else begin
            tick_d = tick_next[TimeoutW-1:0];
          end
        end
      end
      KIND_BYTE: begin
        if (phase_q == PH_WAIT) begin
          if (byte_cnt_q < PktLen) begin
            if (byte_cnt_q == '0) begin
              mode_d = in_i.rx_byte[2:0];
            end else if (byte_cnt_q >= SecFirst && byte_cnt_q < FracFirst) begin
              sec_d = {sec_q[23:0], in_i.rx_byte};
            end else if (byte_cnt_q >= FracFirst) begin
              frac_d = {frac_q[23:0], in_i.rx_byte};
            end
            idx_next = byte_cnt_q + 1'b1;
          end
          byte_cnt_d = idx_next;
          if (in_i.rx_last) begin
            byte_cnt_d = '0;
            if (idx_next >= PktLen) begin
              phase_d  = PH_IDLE;
              tok_ev_d = EV_REPLY;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      retry_q    <= '0;
      tick_q     <= '0;
      byte_cnt_q <= '0;
      mode_q     <= '0;
      sec_q      <= '0;
      frac_q     <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      retry_q    <= retry_d;
      tick_q     <= tick_d;
      byte_cnt_q <= byte_cnt_d;
      mode_q     <= mode_d;
      sec_q      <= sec_d;
      frac_q     <= frac_d;
    end
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      tok_send_q  <= 1'b0;
      tok_ev_q    <= EV_NONE;
    end else if (in_acc) begin
      tok_valid_q <= 1'b1;
      tok_send_q  <= tok_send_d;
      tok_ev_q    <= tok_ev_d;
    end else if (tok_adv) begin
      tok_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tok_mode_q <= mode_d;
      tok_sec_q  <= sec_d;
      tok_frac_q <= frac_d;
    end
  end

  // reply check and conversion to unix milliseconds
  assign secs_rel  = tok_sec_q - EpochOffset;
  assign prod_sec  = {10'd0, secs_rel} * MsPerSec;
  assign prod_frac = {10'd0, tok_frac_q} * MsPerSec;
  assign ms_full   = prod_sec + {32'd0, prod_frac[41:32]};
  assign reply_ok  = (tok_mode_q == 3'd4 || tok_mode_q == 3'd5) && (tok_sec_q >= EpochOffset);

  always_comb begin
    status_d = status_q;
    ms_d     = ms_q;
    done_d   = 1'b0;
    unique case (tok_ev_q)
      EV_NONE: begin
      end
      EV_START: begin
        status_d = ST_BUSY;
        ms_d     = '0;
      end
      EV_TIMEOUT: begin
        status_d = ST_TIMEOUT;
        ms_d     = '0;
        done_d   = 1'b1;
      end
      EV_REPLY: begin
        done_d = 1'b1;
        if (reply_ok) begin
          status_d = ST_OK;
          ms_d     = ms_full[MillisW-1:0];
        end else begin
          status_d = ST_BAD;
          ms_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, also holds the latest status and time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      send_q      <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= ST_BUSY;
      ms_q        <= '0;
    end else if (tok_adv) begin
      out_valid_q <= 1'b1;
      send_q      <= tok_send_q;
      done_q      <= done_d;
      status_q    <= status_d;
      ms_q        <= ms_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.send_query = send_q;
  assign out_o.done_res   = done_q;
  assign out_o.status     = status_q;
  assign out_o.unix_ms    = ms_q;

endmodule
